// ----- rtl/accc_pkg.sv -----
package accc_pkg;

   // Fixed-point format of rates and width of the connection count
   localparam int RATE_FRAC_BITS = 8;
   localparam int COUNT_BITS     = 10;

   localparam int TICK_BITS   = 16;
   localparam int TOTAL_BITS  = 32;
   localparam int RATE_BITS   = TOTAL_BITS + RATE_FRAC_BITS;
   localparam int WEIGHT_BITS = 16;
   localparam int STEP_BITS   = 8;
   localparam int WINDOW_BITS = 10;
   localparam int CFG_COUNT_BITS = 10;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Width that holds any count, step or configured bound plus a carry
   localparam int ALU_BITS =
      ((COUNT_BITS > CFG_COUNT_BITS) ? COUNT_BITS : CFG_COUNT_BITS) + 1;

   // Decision constants: avg*100 is compared with prev*99
   localparam int SCALE_BITS = RATE_BITS + 7;

   // Additive bias of the dynamic window: W - count + 4
   localparam int WINDOW_BIAS = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INCREASE_STEP       = 3'd0,
      CSR_DECREASE_STEP       = 3'd1,
      CSR_SMOOTHING_WEIGHT    = 3'd2,
      CSR_WINDOW_LIMIT        = 3'd3,
      CSR_DYNAMIC_WINDOW      = 3'd4,
      CSR_ADAPT_ENABLE        = 3'd5,
      CSR_MAX_CONNECTIONS     = 3'd6,
      CSR_INITIAL_CONNECTIONS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [TICK_BITS-1:0]  elapsed_ticks;
      logic [TOTAL_BITS-1:0] download_total;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] connection_count;
      logic                  decision_made;
      logic                  action_state;
      logic [RATE_BITS-1:0]  smoothed_rate;
   } rsp_payload_type;

endpackage

// ----- rtl/adaptive_connection_count_controller.sv -----
// Adaptive connection count controller. Each request word carries the ticks
// elapsed since the last wakeup and the amount downloaded in that interval;
// the block derives an unsigned Q32.8 rate (total << 8) / ticks, folds it into
// an exponential average weighted by smoothing_weight (Q0.16 weight of the old
// average, rounded half up), and counts wakeups. When the window fills and
// adaptation is on, it compares avg*100 against prev*99 and steps the
// connection count up (saturating at max_connections) or down (floor 1) in
// hill-climbing fashion; in dynamic mode the window then shrinks to
// min(W, W - count + 4). Every request yields exactly one response word.
// One word is worked on at a time: req_stall is high from acceptance until
// the result is moved into the response register. From acceptance to
// rsp_valid a word passes a bit-serial restoring divider (one quotient bit
// per cycle), a bit-serial multiply-accumulate over the weight bits, a sum
// step, three decision steps (scaling, compare/step, window resize) and an
// output step. The multiply is skipped on the first sample after a window
// close (the sample replaces the average), the decision steps are skipped
// when no decision runs, and the resize step only runs in dynamic mode. The
// response register lets a new request in while a result waits. Zero elapsed
// ticks yield an all-ones rate. Configuration writes take effect at once;
// writing window_limit also reloads the current window, and writing
// initial_connections also reloads the connection count.
module adaptive_connection_count_controller (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  accc_pkg::req_payload_type                req_payload,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output accc_pkg::rsp_payload_type                rsp_payload,
   // configuration write port
   input  logic                                     csr_write,
   input  logic [accc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [accc_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int RB  = accc_pkg::RATE_BITS;
   localparam int CB  = accc_pkg::COUNT_BITS;
   localparam int TB  = accc_pkg::TICK_BITS;
   localparam int WB  = accc_pkg::WEIGHT_BITS;
   localparam int SB  = accc_pkg::STEP_BITS;
   localparam int NB  = accc_pkg::WINDOW_BITS;
   localparam int KB  = accc_pkg::CFG_COUNT_BITS;
   localparam int AB  = accc_pkg::ALU_BITS;
   localparam int MB  = accc_pkg::SCALE_BITS;
   // signed product of weight and (avg - rate), plus headroom for the sum
   localparam int PB  = RB + WB + 2;
   localparam int STEP_CNT_BITS = $clog2(RB);
   localparam logic [AB-1:0] COUNT_MAX = AB'((1 << CB) - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIV    = 8'b0000_0010,
      ST_MAC    = 8'b0000_0100,
      ST_SUM    = 8'b0000_1000,
      ST_SCALE  = 8'b0001_0000,
      ST_DECIDE = 8'b0010_0000,
      ST_RESIZE = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SB-1:0] inc_step_ff, inc_step_in;
   logic [SB-1:0] dec_step_ff, dec_step_in;
   logic [WB-1:0] weight_ff, weight_in;
   logic [NB-1:0] win_limit_ff, win_limit_in;
   logic          dyn_ff, dyn_in;
   logic          adapt_ff, adapt_in;
   logic [KB-1:0] max_conn_ff, max_conn_in;
   logic [KB-1:0] init_conn_ff, init_conn_in;

   // controller state
   logic [RB-1:0] avg_ff, avg_in;
   logic [RB-1:0] prev_ff, prev_in;
   logic [NB-1:0] wake_cnt_ff, wake_cnt_in;
   logic [NB-1:0] cur_win_ff, cur_win_in;
   logic [CB-1:0] count_ff, count_in;
   logic          last_inc_ff, last_inc_in;

   // serial datapath
   logic [TB-1:0]            ticks_ff, ticks_in;
   logic [RB-1:0]            quot_ff, quot_in;     // dividend in, quotient out
   logic [TB:0]              rem_ff, rem_in;
   logic [WB-1:0]            wsh_ff, wsh_in;       // weight, MSB first
   logic [PB-1:0]            prod_ff, prod_in;
   logic [MB-1:0]            lhs_ff, lhs_in;
   logic [MB-1:0]            rhs_ff, rhs_in;
   logic [STEP_CNT_BITS-1:0] step_ff, step_in;
   logic                     decided_ff, decided_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   accc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // combinational helpers
   logic [TB:0]          div_trial;
   logic                 div_ge;
   logic signed [RB:0]   diff;
   logic [PB-1:0]        ema_sum;
   logic [NB:0]          cnt_inc;
   logic [NB-1:0]        win_eff;
   logic                 win_close;
   logic [AB-1:0]        raise_sum, raise_lim, raised;
   logic [AB-1:0]        lower_res;
   logic [AB-1:0]        rs_base, rs_diff, rs_w;
   logic                 cmp_lt, cmp_gt;

   function automatic logic [NB-1:0] eff_window(input logic [NB-1:0] w);
      eff_window = (w == '0) ? NB'(1) : w;
   endfunction

   function automatic logic [CB-1:0] eff_initial(input logic [KB-1:0] v);
      logic [AB-1:0] t;
      t = AB'(v);
      if (t == '0) begin
         t = AB'(1);
      end
      if (t > COUNT_MAX) begin
         t = COUNT_MAX;
      end
      eff_initial = t[CB-1:0];
   endfunction

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // restoring divide step
   assign div_trial = {rem_ff[TB-1:0], quot_ff[RB-1]};
   assign div_ge    = (div_trial >= {1'b0, ticks_ff});

   // avg*w + rate*(1-w) = rate + w*(avg - rate)
   assign diff    = $signed({1'b0, avg_ff}) - $signed({1'b0, quot_ff});
   assign ema_sum = prod_ff + (PB'(quot_ff) << WB) + PB'(1 << (WB - 1));

   // window bookkeeping
   assign win_eff   = eff_window(cur_win_ff);
   assign cnt_inc   = {1'b0, wake_cnt_ff} + (NB+1)'(1);
   assign win_close = (cnt_inc >= {1'b0, win_eff});

   // count steps
   always_comb begin
      raise_sum = AB'(count_ff) + AB'(inc_step_ff);
      raise_lim = AB'(max_conn_ff);
      if (raise_lim == '0) begin
         raise_lim = AB'(1);
      end
      if (raise_lim > COUNT_MAX) begin
         raise_lim = COUNT_MAX;
      end
      raised = (raise_sum < raise_lim) ? raise_sum : raise_lim;
      if (AB'(count_ff) > AB'(dec_step_ff) + AB'(1)) begin
         lower_res = AB'(count_ff) - AB'(dec_step_ff);
      end else begin
         lower_res = AB'(1);
      end
   end

   // dynamic window: min(W, W - count + 4), at least 1
   always_comb begin
      rs_w    = AB'(eff_window(win_limit_ff));
      rs_base = rs_w + AB'(accc_pkg::WINDOW_BIAS);
      if (rs_base > AB'(count_ff)) begin
         rs_diff = rs_base - AB'(count_ff);
      end else begin
         rs_diff = AB'(1);
      end
      if (rs_diff > rs_w) begin
         rs_diff = rs_w;
      end
   end

   assign cmp_lt = (lhs_ff < rhs_ff);
   assign cmp_gt = (lhs_ff > rhs_ff);

   always_comb begin
      state_in       = state_ff;
      inc_step_in    = inc_step_ff;
      dec_step_in    = dec_step_ff;
      weight_in      = weight_ff;
      win_limit_in   = win_limit_ff;
      dyn_in         = dyn_ff;
      adapt_in       = adapt_ff;
      max_conn_in    = max_conn_ff;
      init_conn_in   = init_conn_ff;
      avg_in         = avg_ff;
      prev_in        = prev_ff;
      wake_cnt_in    = wake_cnt_ff;
      cur_win_in     = cur_win_ff;
      count_in       = count_ff;
      last_inc_in    = last_inc_ff;
      ticks_in       = ticks_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      wsh_in         = wsh_ff;
      prod_in        = prod_ff;
      lhs_in         = lhs_ff;
      rhs_in         = rhs_ff;
      step_in        = step_ff;
      decided_in     = decided_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ticks_in = req_payload.elapsed_ticks;
               quot_in  = RB'({req_payload.download_total, {accc_pkg::RATE_FRAC_BITS{1'b0}}});
               rem_in   = '0;
               step_in  = STEP_CNT_BITS'(RB - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle; a zero divisor gives all ones
            quot_in = {quot_ff[RB-2:0], div_ge};
            rem_in  = div_ge ? (div_trial - {1'b0, ticks_ff}) : div_trial;
            step_in = step_ff - STEP_CNT_BITS'(1);
            if (step_ff == '0) begin
               wsh_in  = weight_ff;
               prod_in = '0;
               step_in = STEP_CNT_BITS'(WB - 1);
               // first sample after a close replaces the average
               state_in = (wake_cnt_ff == '0) ? ST_SUM : ST_MAC;
            end
         end
         ST_MAC: begin
            prod_in = (prod_ff << 1) + (wsh_ff[WB-1] ? PB'(diff) : PB'(0));
            wsh_in  = wsh_ff << 1;
            step_in = step_ff - STEP_CNT_BITS'(1);
            if (step_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            avg_in      = (wake_cnt_ff == '0) ? quot_ff : ema_sum[WB +: RB];
            wake_cnt_in = win_close ? NB'(0) : cnt_inc[NB-1:0];
            decided_in  = win_close && adapt_ff;
            state_in    = (win_close && adapt_ff) ? ST_SCALE : ST_DONE;
         end
         ST_SCALE: begin
            lhs_in = (MB'(avg_ff) << 6) + (MB'(avg_ff) << 5) + (MB'(avg_ff) << 2);
            rhs_in = (MB'(prev_ff) << 6) + (MB'(prev_ff) << 5) + (MB'(prev_ff) << 2)
                     - MB'(prev_ff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (avg_ff != '0) begin
               if (cmp_lt) begin
                  // rate fell: reverse direction
                  count_in    = last_inc_ff ? lower_res[CB-1:0] : raised[CB-1:0];
                  last_inc_in = !last_inc_ff;
               end else if (cmp_gt) begin
                  // rate held up: keep going
                  count_in    = last_inc_ff ? raised[CB-1:0] : lower_res[CB-1:0];
               end
            end
            prev_in  = avg_ff;
            avg_in   = '0;
            state_in = dyn_ff ? ST_RESIZE : ST_DONE;
         end
         ST_RESIZE: begin
            cur_win_in = rs_diff[NB-1:0];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in.connection_count = count_ff;
               rsp_payload_in.decision_made    = decided_ff;
               rsp_payload_in.action_state     = last_inc_ff;
               rsp_payload_in.smoothed_rate    = avg_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes (the user must issue them only while idle; the block does not enforce it)
      if (csr_write) begin
         unique case (accc_pkg::csr_index_type'(csr_index))
            accc_pkg::CSR_INCREASE_STEP:    inc_step_in = csr_wdata[SB-1:0];
            accc_pkg::CSR_DECREASE_STEP:    dec_step_in = csr_wdata[SB-1:0];
            accc_pkg::CSR_SMOOTHING_WEIGHT: weight_in   = csr_wdata[WB-1:0];
            accc_pkg::CSR_WINDOW_LIMIT: begin
               win_limit_in = csr_wdata[NB-1:0];
               cur_win_in   = eff_window(csr_wdata[NB-1:0]);
            end
            accc_pkg::CSR_DYNAMIC_WINDOW:   dyn_in      = csr_wdata[0];
            accc_pkg::CSR_ADAPT_ENABLE:     adapt_in    = csr_wdata[0];
            accc_pkg::CSR_MAX_CONNECTIONS:  max_conn_in = csr_wdata[KB-1:0];
            accc_pkg::CSR_INITIAL_CONNECTIONS: begin
               init_conn_in = csr_wdata[KB-1:0];
               count_in     = eff_initial(csr_wdata[KB-1:0]);
            end
            default: begin
               inc_step_in = inc_step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         inc_step_ff  <= SB'(2);
         dec_step_ff  <= SB'(3);
         weight_ff    <= WB'(13107);
         win_limit_ff <= NB'(100);
         dyn_ff       <= 1'b0;
         adapt_ff     <= 1'b1;
         max_conn_ff  <= KB'(98);
         init_conn_ff <= KB'(5);
         avg_ff       <= '0;
         prev_ff      <= '0;
         wake_cnt_ff  <= '0;
         cur_win_ff   <= NB'(100);
         count_ff     <= eff_initial(KB'(5));
         last_inc_ff  <= 1'b0;
         step_ff      <= '0;
         decided_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         inc_step_ff  <= inc_step_in;
         dec_step_ff  <= dec_step_in;
         weight_ff    <= weight_in;
         win_limit_ff <= win_limit_in;
         dyn_ff       <= dyn_in;
         adapt_ff     <= adapt_in;
         max_conn_ff  <= max_conn_in;
         init_conn_ff <= init_conn_in;
         avg_ff       <= avg_in;
         prev_ff      <= prev_in;
         wake_cnt_ff  <= wake_cnt_in;
         cur_win_ff   <= cur_win_in;
         count_ff     <= count_in;
         last_inc_ff  <= last_inc_in;
         step_ff      <= step_in;
         decided_ff   <= decided_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      ticks_ff       <= ticks_in;
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      wsh_ff         <= wsh_in;
      prod_ff        <= prod_in;
      lhs_ff         <= lhs_in;
      rhs_ff         <= rhs_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // an accepted word always starts the divider
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DIV))
      else $error("accepted word did not start the divider");

   // a new response is only raised from the output state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(state_ff == ST_DONE))
      else $error("response raised outside the output state");

   // the connection count never reaches zero
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.connection_count != '0))
      else $error("connection count of zero");

   // a decision clears the average it consumed
   a_decision_clears_avg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.decision_made) |->
         (rsp_payload_ff.smoothed_rate == '0))
      else $error("decision left a nonzero average");

endmodule

// ----- tb/accc_tb_pkg.sv -----
package accc_tb_pkg;
   import accc_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int unsigned COUNT_CEILING = (1 << COUNT_BITS) - 1;

   class connection_scoreboard;
      // register copies
      logic [STEP_BITS-1:0]      increase_step;
      logic [STEP_BITS-1:0]      decrease_step;
      logic [WEIGHT_BITS-1:0]    smoothing_weight;
      logic [WINDOW_BITS-1:0]    window_limit;
      logic                      dynamic_window;
      logic                      adapt_enable;
      logic [CFG_COUNT_BITS-1:0] max_connections;
      logic [CFG_COUNT_BITS-1:0] initial_connections;

      // controller state
      logic [RATE_BITS-1:0] rate_average;
      logic [RATE_BITS-1:0] decision_average;
      int unsigned          wakeups_in_window;
      int unsigned          window_length;
      int unsigned          connections;
      logic                 raised_last;

      rsp_payload_type expected_results[$];
      int unsigned wakeups_seen;
      int unsigned decisions_seen;
      int unsigned raises_seen;
      int unsigned lowers_seen;
      int unsigned failures;

      function new();
         increase_step       = 8'd2;
         decrease_step       = 8'd3;
         smoothing_weight    = 16'd13107;
         window_limit        = 10'd100;
         dynamic_window      = 1'b0;
         adapt_enable        = 1'b1;
         max_connections     = 10'd98;
         initial_connections = 10'd5;
         rate_average        = '0;
         decision_average    = '0;
         wakeups_in_window   = 0;
         window_length       = window_floor();
         connections         = initial_floor();
         raised_last         = 1'b0;
         wakeups_seen        = 0;
         decisions_seen      = 0;
         raises_seen         = 0;
         lowers_seen         = 0;
         failures            = 0;
      endfunction

      function int unsigned window_floor();
         return (window_limit == 0) ? 1 : window_limit;
      endfunction

      function int unsigned initial_floor();
         int unsigned v;
         v = (initial_connections == 0) ? 1 : initial_connections;
         return (v > COUNT_CEILING) ? COUNT_CEILING : v;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      function void apply_register(csr_index_type index, logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_INCREASE_STEP:    increase_step    = value[STEP_BITS-1:0];
            CSR_DECREASE_STEP:    decrease_step    = value[STEP_BITS-1:0];
            CSR_SMOOTHING_WEIGHT: smoothing_weight = value[WEIGHT_BITS-1:0];
            CSR_WINDOW_LIMIT: begin
               window_limit  = value[WINDOW_BITS-1:0];
               window_length = window_floor();
            end
            CSR_DYNAMIC_WINDOW:   dynamic_window   = value[0];
            CSR_ADAPT_ENABLE:     adapt_enable     = value[0];
            CSR_MAX_CONNECTIONS:  max_connections  = value[CFG_COUNT_BITS-1:0];
            CSR_INITIAL_CONNECTIONS: begin
               initial_connections = value[CFG_COUNT_BITS-1:0];
               connections         = initial_floor();
            end
            default: ;
         endcase
      endfunction

      // saturating add; a count above the bound drops to the bound
      function void raise_connections();
         int unsigned bound;
         bound = (max_connections == 0) ? 1 : max_connections;
         if (bound > COUNT_CEILING) bound = COUNT_CEILING;
         connections = (connections + increase_step < bound) ?
                       connections + increase_step : bound;
         raises_seen++;
      endfunction

      function void lower_connections();
         if (connections > decrease_step + 1) connections = connections - decrease_step;
         else connections = 1;
         lowers_seen++;
      endfunction

      function void predict_wakeup_result(req_payload_type word);
         logic [63:0]          dividend;
         logic [63:0]          blend;
         logic [63:0]          scaled_now;
         logic [63:0]          scaled_then;
         logic [RATE_BITS-1:0] instant_rate;
         int unsigned          closing_window;
         int                   resized;
         rsp_payload_type      outcome;

         outcome.decision_made = 1'b0;
         if (word.elapsed_ticks == 0) begin
            instant_rate = '1;
         end else begin
            dividend     = 64'(word.download_total) << RATE_FRAC_BITS;
            instant_rate = RATE_BITS'(dividend / 64'(word.elapsed_ticks));
         end

         // first sample of a window replaces the average
         if (wakeups_in_window == 0) begin
            rate_average = instant_rate;
         end else begin
            blend = 64'(smoothing_weight) * 64'(rate_average)
                  + (64'd65536 - 64'(smoothing_weight)) * 64'(instant_rate) + 64'd32768;
            rate_average = RATE_BITS'(blend >> 16);
         end

         closing_window = (window_length == 0) ? 1 : window_length;
         wakeups_in_window++;
         if (wakeups_in_window >= closing_window) begin
            if (adapt_enable) begin
               if (rate_average != 0) begin
                  scaled_now  = 64'(rate_average) * 64'd100;
                  scaled_then = 64'(decision_average) * 64'd99;
                  if (scaled_now < scaled_then) begin
                     if (raised_last) lower_connections();
                     else raise_connections();
                     raised_last = !raised_last;
                  end else if (scaled_now > scaled_then) begin
                     if (raised_last) raise_connections();
                     else lower_connections();
                  end
               end
               if (dynamic_window) begin
                  resized = int'(window_floor()) - int'(connections) + WINDOW_BIAS;
                  if (resized > int'(window_floor())) resized = window_floor();
                  if (resized < 1) resized = 1;
                  window_length = resized;
               end
               decision_average      = rate_average;
               rate_average          = '0;
               outcome.decision_made = 1'b1;
               decisions_seen++;
            end
            wakeups_in_window = 0;
         end

         outcome.connection_count = COUNT_BITS'(connections);
         outcome.action_state     = raised_last;
         outcome.smoothed_rate    = rate_average;
         expected_results.insert(expected_results.size(), outcome);
         wakeups_seen++;
      endfunction

      function void check_wakeup_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result word: count %0d decided %0b action %0b rate %h",
                        got.connection_count, got.decision_made, got.action_state,
                        got.smoothed_rate);
            return;
         end
         want = expected_results.pop_front();
         if (got.connection_count !== want.connection_count ||
             got.decision_made !== want.decision_made ||
             got.action_state !== want.action_state ||
             got.smoothed_rate !== want.smoothed_rate) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch exp/act: count %0d/%0d decided %0b/%0b %s%0b/%0b %s%h/%h",
                        want.connection_count, got.connection_count,
                        want.decision_made, got.decision_made,
                        "action ", want.action_state, got.action_state,
                        "rate ", want.smoothed_rate, got.smoothed_rate);
         end
      endfunction
   endclass

endpackage

// ----- tb/testbench.sv -----
module testbench;
   import accc_pkg::*;
   import accc_tb_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int QUIET_LIMIT     = 4000;   // cycles with no word moving on either side
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 100;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_WORDS     = 83;
   localparam int CALM_PHASE      = 3;      // no idling on either side
   localparam int HOLD_OFF_PHASE  = 6;      // receiver blocks for a long stretch

   typedef struct {
      int unsigned increase_step;
      int unsigned decrease_step;
      int unsigned smoothing_weight;
      int unsigned window_limit;
      int unsigned dynamic_window;
      int unsigned adapt_enable;
      int unsigned max_connections;
      int unsigned initial_connections;
   } controller_setup_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   req_payload_type                req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   rsp_payload_type                rsp_payload;
   logic                           csr_write   = 1'b0;
   csr_index_type                  csr_index   = CSR_INCREASE_STEP;
   logic [CSR_DATA_BITS-1:0]       csr_wdata   = '0;

   int unsigned          idle_percent     = 32;
   bit                   hold_off_request = 1'b0;
   int unsigned          quiet_cycles     = 0;
   connection_scoreboard board;

   adaptive_connection_count_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Response side: random stalls, or one long hold-off on request. The
   // hold-off is counted here so the sender keeps offering words meanwhile
   // and the block backs up into req_stall.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_percent);
         end
      end
   end

   // Sample at the rising edge; outputs still hold their pre-edge values.
   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall)
         board.check_wakeup_result(rsp_payload);
   end

   // Watchdog: a hang shows up as a long stretch with no word moving.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout after %0d idle cycles, %0d results outstanding",
               quiet_cycles, board.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic controller_setup_type make_setup(
      int unsigned inc, int unsigned dec, int unsigned weight, int unsigned window,
      int unsigned dynamic, int unsigned adapt, int unsigned max_count,
      int unsigned first_count);
      controller_setup_type s;
      s.increase_step       = inc;
      s.decrease_step       = dec;
      s.smoothing_weight    = weight;
      s.window_limit        = window;
      s.dynamic_window      = dynamic;
      s.adapt_enable        = adapt;
      s.max_connections     = max_count;
      s.initial_connections = first_count;
      return s;
   endfunction

   function automatic req_payload_type make_word(logic [TICK_BITS-1:0] ticks,
                                                 logic [TOTAL_BITS-1:0] total);
      req_payload_type word;
      word.elapsed_ticks  = ticks;
      word.download_total = total;
      return word;
   endfunction

   function automatic int unsigned random_step();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   function automatic int unsigned random_count();
      case ($urandom_range(9))
         0:          return 0;
         1:          return 1023;
         2, 3, 4, 5: return $urandom_range(1, 30);
         default:    return $urandom_range(1, 1023);
      endcase
   endfunction

   // Mostly short windows so decisions come often
   function automatic controller_setup_type random_setup();
      controller_setup_type s;
      s.increase_step = random_step();
      s.decrease_step = random_step();
      case ($urandom_range(5))
         0:       s.smoothing_weight = 0;
         1:       s.smoothing_weight = 65535;
         default: s.smoothing_weight = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(9))
         0:       s.window_limit = 0;
         1:       s.window_limit = $urandom_range(7, 40);
         default: s.window_limit = $urandom_range(1, 6);
      endcase
      s.dynamic_window      = $urandom_range(1);
      s.adapt_enable        = ($urandom_range(7) != 0);
      s.max_connections     = random_count();
      s.initial_connections = random_count();
      return s;
   endfunction

   // 256 ticks makes the rate equal to the total, handy for close calls
   function automatic req_payload_type random_word();
      req_payload_type word;
      case ($urandom_range(19))
         0:             word.elapsed_ticks = '0;
         1:             word.elapsed_ticks = 16'd1;
         2:             word.elapsed_ticks = '1;
         3, 4, 5:       word.elapsed_ticks = 16'd256;
         6, 7, 8:       word.elapsed_ticks = TICK_BITS'($urandom_range(1, 512));
         default:       word.elapsed_ticks = TICK_BITS'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(9))
         0:       word.download_total = '0;
         1:       word.download_total = '1;
         2, 3, 4: word.download_total = $urandom_range(0, 4095);
         default: word.download_total = $urandom;
      endcase
      return word;
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic store_register(input csr_index_type index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.apply_register(index, value);
      @(negedge clock);
   endtask

   task automatic apply_setup(input controller_setup_type s);
      store_register(CSR_INCREASE_STEP,       CSR_DATA_BITS'(s.increase_step));
      store_register(CSR_DECREASE_STEP,       CSR_DATA_BITS'(s.decrease_step));
      store_register(CSR_SMOOTHING_WEIGHT,    CSR_DATA_BITS'(s.smoothing_weight));
      store_register(CSR_WINDOW_LIMIT,        CSR_DATA_BITS'(s.window_limit));
      store_register(CSR_DYNAMIC_WINDOW,      CSR_DATA_BITS'(s.dynamic_window));
      store_register(CSR_ADAPT_ENABLE,        CSR_DATA_BITS'(s.adapt_enable));
      store_register(CSR_MAX_CONNECTIONS,     CSR_DATA_BITS'(s.max_connections));
      store_register(CSR_INITIAL_CONNECTIONS, CSR_DATA_BITS'(s.initial_connections));
      csr_write <= 1'b0;
   endtask

   // Valid stays high after acceptance; the next call or a gap decides.
   task automatic send_wakeup(input req_payload_type word);
      req_payload <= word;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.predict_wakeup_result(word);
      @(negedge clock);
   endtask

   // Mostly short gaps, now and then one longer than a whole word's latency
   task automatic sender_gap();
      if ($urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(4) == 0) ? 70 : 5)) @(negedge clock);
      end
   endtask

   // Every word yields one result, so the block is idle once none is owed.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   initial begin
      int unsigned phase;

      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Window of one: every wakeup decides and the sample replaces the
      // average. 100 then 99 lands exactly on the 0.99 line (no change),
      // 50 flips the action, 200 repeats it, 0 leaves the count alone.
      apply_setup(make_setup(2, 3, 0, 1, 0, 1, 98, 5));
      send_wakeup(make_word(16'd256, 32'd100));
      send_wakeup(make_word(16'd256, 32'd99));
      send_wakeup(make_word(16'd256, 32'd50));
      send_wakeup(make_word(16'd256, 32'd200));
      send_wakeup(make_word(16'd256, 32'd0));
      send_wakeup(make_word(16'd0, 32'h1234_5678));        // divider gives all ones
      send_wakeup(make_word(16'd1, 32'hFFFF_FFFF));
      send_wakeup(make_word(16'hFFFF, 32'd0));
      send_wakeup(make_word(16'hFFFF, 32'hFFFF_FFFF));
      wait_drained();

      // Zero window, zero bound and zero initial count all clamp to one
      apply_setup(make_setup(255, 255, 65535, 0, 1, 1, 0, 0));
      send_wakeup(make_word(16'd256, 32'd300));
      send_wakeup(make_word(16'd256, 32'd100));
      wait_drained();

      // Full count in dynamic mode: window collapses to one after a decision
      apply_setup(make_setup(255, 0, 32768, 2, 1, 1, 1023, 1023));
      send_wakeup(make_word(16'd256, 32'd1000));
      send_wakeup(make_word(16'd256, 32'd3000));
      send_wakeup(make_word(16'd256, 32'd10));
      wait_drained();

      // Adaptation off: window wraps without a decision
      apply_setup(make_setup(2, 3, 13107, 3, 0, 0, 98, 5));
      send_wakeup(make_word(16'd300, 32'd5000));
      send_wakeup(make_word(16'd7, 32'd123456));
      send_wakeup(make_word(16'hFFFF, 32'd1));
      wait_drained();

      // Count far above a bound written later: the next raise clamps to it
      apply_setup(make_setup(200, 3, 0, 1, 0, 1, 1023, 900));
      send_wakeup(make_word(16'd256, 32'd100));
      send_wakeup(make_word(16'd256, 32'd50));
      wait_drained();
      store_register(CSR_MAX_CONNECTIONS, CSR_DATA_BITS'(10));
      csr_write <= 1'b0;
      send_wakeup(make_word(16'd256, 32'd400));
      send_wakeup(make_word(16'd256, 32'd25));
      wait_drained();

      // Window cut below the wakeup counter closes at the next word
      apply_setup(make_setup(2, 3, 13107, 20, 0, 1, 98, 5));
      send_wakeup(random_word());
      send_wakeup(random_word());
      send_wakeup(random_word());
      wait_drained();
      store_register(CSR_WINDOW_LIMIT, CSR_DATA_BITS'(2));
      csr_write <= 1'b0;
      send_wakeup(random_word());
      wait_drained();

      // Random phases: the first two hold the registers at their top and near
      // their bottom, the rest draw settings. One phase runs without idling, one
      // carries the long response hold-off.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            apply_setup(make_setup(255, 255, 65535, 1023, 1, 1, 1023, 1023));
         else if (phase == 1)
            apply_setup(make_setup(0, 0, 0, 1, 0, 1, 1, 1));
         else
            apply_setup(random_setup());
         idle_percent = (phase == CALM_PHASE) ? 0 : 32;
         if (phase == HOLD_OFF_PHASE) hold_off_request = 1'b1;
         repeat (PHASE_WORDS) begin
            // occasionally the sender waits for every result before going on
            if ($urandom_range(59) == 0) wait_drained();
            else sender_gap();
            send_wakeup(random_word());
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d wakeups over %0d register setups: %0d decisions, %0d raises,",
               board.wakeups_seen, RANDOM_PHASES + 6, board.decisions_seen,
               board.raises_seen);
      $display("%0d lowers; zero ticks, clamped registers, dynamic windows, %0d-cycle hold-off.",
               board.lowers_seen, HOLD_OFF_CYCLES);
      if (board.failures == 0 && board.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/accc_pkg.sv
rtl/adaptive_connection_count_controller.sv
tb/accc_tb_pkg.sv
tb/testbench.sv
